[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hdl/u8cv_pkg.sv]
// Types, widths and the wide-character interval table of the UTF-8 classifier.
package u8cv_pkg;

   localparam int REQ_BITS    = 35;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_BITS    = 35;
   localparam int RSP_TDATA_W = 40;
   localparam int NUM_WIDE    = 36;

   typedef struct packed {
      logic [2:0] available_bytes;
      logic [7:0] byte_3;
      logic [7:0] byte_2;
      logic [7:0] byte_1;
      logic [7:0] byte_0;
   } req_fields_type;

   typedef struct packed {
      logic [2:0]  advance;
      logic [4:0]  columns;
      logic        wide;
      logic        printable;
      logic [20:0] code_point;
      logic [2:0]  char_len;
      logic        char_valid;
   } rsp_fields_type;

   localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
      21'h01100, 21'h02329, 21'h02E80, 21'h02E9B, 21'h02F00, 21'h02FF0,
      21'h03000, 21'h03041, 21'h03099, 21'h03105, 21'h03131, 21'h03190,
      21'h031C0, 21'h031F0, 21'h03220, 21'h03250, 21'h03300, 21'h04E00,
      21'h0A490, 21'h0A960, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30,
      21'h0FE54, 21'h0FE68, 21'h0FF01, 21'h0FFE0, 21'h1B000, 21'h1F200,
      21'h1F210, 21'h1F240, 21'h1F250, 21'h1F300, 21'h20000, 21'h30000
   };

   localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
      21'h0115F, 21'h0232A, 21'h02E99, 21'h02EF3, 21'h02FD5, 21'h02FFB,
      21'h0303E, 21'h03096, 21'h030FF, 21'h0312D, 21'h0318E, 21'h031BA,
      21'h031E3, 21'h0321E, 21'h03247, 21'h032FE, 21'h04DBF, 21'h0A48C,
      21'h0A4C6, 21'h0A97C, 21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE52,
      21'h0FE66, 21'h0FE6B, 21'h0FF60, 21'h0FFE6, 21'h1B001, 21'h1F202,
      21'h1F23A, 21'h1F248, 21'h1F251, 21'h1F567, 21'h2FFFD, 21'h3FFFD
   };

   // The intervals are compared in parallel and the hits ORed together.
   function automatic logic is_wide(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_WIDE; i++) begin
         if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Sequence length implied by the leading byte; 0 for continuation bytes,
   // the five- and six-byte leaders and 0xFE/0xFF.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

endpackage

[hdl/utf8_char_validate_classify_unit.sv]
// UTF-8 character validator and classifier, top level.
// Path: an input transfer is held in the input register, then loaded into the result register
// once that register is free or being drained; rsp_tvalid rises when the result register loads.
// Throughput: one character window per cycle unless rsp_tready stalls the result; the decode,
// range checks and the 36 parallel interval compares all sit between the two registers.
// Reset clears both valid flags and makes a linefeed printable; payload registers are not reset.
module utf8_char_validate_classify_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // byte_0 [7:0], byte_1 [15:8], byte_2 [23:16], byte_3 [31:24], available_bytes [34:32]
   input  logic [u8cv_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // char_valid [0], char_len [3:1], code_point [24:4], printable [25], wide [26],
   // columns [31:27], advance [34:32]
   output logic [u8cv_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data
);

   logic                     lf_printable_ff, lf_printable_in;
   logic                     s1_valid_ff, s1_valid_in;
   u8cv_pkg::req_fields_type s1_data_ff, s1_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   u8cv_pkg::rsp_fields_type rsp_data_ff, rsp_data_in;

   logic        rsp_load;
   logic        req_fire;
   logic [2:0]  lead_len;
   logic [2:0]  avail_eff;
   logic        cont_ok;
   logic [20:0] cp_raw;
   logic        overlong;
   logic        scalar_ok;
   logic        char_ok;
   logic [20:0] cp;
   logic        prn;
   logic        wd;

   assign csr_ready = 1'b1;
   assign lf_printable_in = (csr_valid && csr_ready) ? csr_data : lf_printable_ff;

   // The input stage empties whenever the result register is free or being drained.
   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (rsp_load ? 1'b0 : s1_valid_ff);
   assign s1_data_in   = req_fire ? u8cv_pkg::req_fields_type'(req_tdata[u8cv_pkg::REQ_BITS-1:0])
                                  : s1_data_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Decode and checks on the registered window.
   always_comb begin
      lead_len  = u8cv_pkg::lead_length(s1_data_ff.byte_0);
      avail_eff = (s1_data_ff.available_bytes > 3'd4) ? 3'd4 : s1_data_ff.available_bytes;

      cont_ok = 1'b1;
      if (lead_len >= 3'd2 && s1_data_ff.byte_1[7:6] != 2'b10) begin
         cont_ok = 1'b0;
      end
      if (lead_len >= 3'd3 && s1_data_ff.byte_2[7:6] != 2'b10) begin
         cont_ok = 1'b0;
      end
      if (lead_len == 3'd4 && s1_data_ff.byte_3[7:6] != 2'b10) begin
         cont_ok = 1'b0;
      end

      case (lead_len)
         3'd1: begin
            cp_raw   = {13'd0, s1_data_ff.byte_0};
            overlong = 1'b0;
         end
         3'd2: begin
            cp_raw   = {10'd0, s1_data_ff.byte_0[4:0], s1_data_ff.byte_1[5:0]};
            overlong = (cp_raw < 21'h00080);
         end
         3'd3: begin
            cp_raw   = {5'd0, s1_data_ff.byte_0[3:0], s1_data_ff.byte_1[5:0],
                        s1_data_ff.byte_2[5:0]};
            overlong = (cp_raw < 21'h00800);
         end
         3'd4: begin
            cp_raw   = {s1_data_ff.byte_0[2:0], s1_data_ff.byte_1[5:0],
                        s1_data_ff.byte_2[5:0], s1_data_ff.byte_3[5:0]};
            overlong = (cp_raw < 21'h10000);
         end
         default: begin
            cp_raw   = 21'd0;
            overlong = 1'b0;
         end
      endcase

      // Rejects values past the last plane, surrogates and the noncharacters.
      scalar_ok = !(cp_raw >= 21'h110000)
               && !(cp_raw[20:11] == 10'h01B)
               && !(cp_raw >= 21'h0FDD0 && cp_raw <= 21'h0FDEF)
               && !(cp_raw[15:1] == 15'h7FFF);

      char_ok = (lead_len != 3'd0) && (lead_len <= avail_eff) && cont_ok
             && !overlong && scalar_ok;
      cp = char_ok ? cp_raw : 21'd0;

      prn = char_ok;
      if (cp < 21'h00020 && cp != 21'h00009 && cp != 21'h0000A) begin
         prn = 1'b0;
      end
      if (cp >= 21'h0007F && cp <= 21'h0009F) begin
         prn = 1'b0;
      end
      if (cp == 21'h0000A && !lf_printable_ff) begin
         prn = 1'b0;
      end
      wd = char_ok && u8cv_pkg::is_wide(cp);

      rsp_data_in.char_valid = char_ok;
      rsp_data_in.char_len   = char_ok ? lead_len : 3'd0;
      rsp_data_in.code_point = cp;
      rsp_data_in.printable  = prn;
      rsp_data_in.wide       = wd;
      if (!char_ok) begin
         rsp_data_in.columns = 5'd1;
      end else if (prn) begin
         rsp_data_in.columns = wd ? 5'd2 : 5'd1;
      end else begin
         rsp_data_in.columns = {lead_len, 2'b00};
      end
      rsp_data_in.advance = char_ok ? lead_len : 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_printable_ff <= 1'b1;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         lf_printable_ff <= lf_printable_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(u8cv_pkg::RSP_TDATA_W - u8cv_pkg::RSP_BITS){1'b0}}, rsp_data_ff};

endmodule

[hdl/u8cv_checker.sv]
// Port-level assertions for the UTF-8 classifier and the bind that attaches them.
`include "assert_macros.svh"

module u8cv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [u8cv_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   u8cv_pkg::rsp_fields_type rsp_f;
   logic                     rsp_stall;
   logic                     req_fire;
   logic                     invalid_shape;
   logic                     valid_shape;

   assign rsp_f     = u8cv_pkg::rsp_fields_type'(rsp_tdata[u8cv_pkg::RSP_BITS-1:0]);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_fire  = req_tvalid && req_tready;

   assign invalid_shape = rsp_f.char_len == 3'd0 && rsp_f.code_point == 21'd0
                       && !rsp_f.printable && !rsp_f.wide
                       && rsp_f.columns == 5'd1 && rsp_f.advance == 3'd1;
   assign valid_shape   = rsp_f.advance == rsp_f.char_len && rsp_f.char_len != 3'd0
                       && (!rsp_f.printable || rsp_f.columns == 5'd1
                           || rsp_f.columns == 5'd2);

   // A stalled result keeps its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // Once an input transfer has passed the input register, the result side always holds a result.
   `ASSERT_IMPLY(a_req_to_rsp, clock, reset, req_fire, ##2 rsp_tvalid)

   // A rejected character carries the fixed invalid result.
   `ASSERT_IMPLY(a_invalid_fields, clock, reset, rsp_tvalid && !rsp_f.char_valid, invalid_shape)

   // A decoded character advances by its own length, and a printable one takes one or two columns.
   `ASSERT_IMPLY(a_valid_fields, clock, reset, rsp_tvalid && rsp_f.char_valid, valid_shape)

endmodule

bind utf8_char_validate_classify_unit u8cv_checker u_u8cv_checker (.*);
